// ===== design/nfc_response_frame_checker_defines.svh =====
// Assertion helpers for the response frame checker.
`ifndef NFC_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define NFC_RESPONSE_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NFCRFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame checker: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define NFCRFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame checker: next-cycle check failed");

`endif

// ===== design/nfcrfc_pkg.sv =====
`timescale 1ns / 1ps

package nfcrfc_pkg;

  localparam int unsigned ACK_BYTES = 6;
  localparam int unsigned OFF_LEN   = 3;
  localparam int unsigned OFF_TFI   = 5;
  localparam int unsigned MIN_TAIL  = 4;

  localparam int unsigned COUNT_W   = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Fixed frame offsets, counted from the first byte of the window
  localparam logic [COUNT_W-1:0] POS_LEN    = COUNT_W'(ACK_BYTES + OFF_LEN);
  localparam logic [COUNT_W-1:0] POS_LCS    = COUNT_W'(ACK_BYTES + OFF_LEN + 1);
  localparam logic [COUNT_W-1:0] POS_DATA   = COUNT_W'(ACK_BYTES + OFF_TFI);
  localparam logic [COUNT_W-1:0] POS_STATUS = COUNT_W'(ACK_BYTES + OFF_TFI + 2);
  localparam logic [COUNT_W-1:0] MIN_COUNT  = COUNT_W'(ACK_BYTES + OFF_TFI + MIN_TAIL);

  // Item kind carried on tuser
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_TOO_SHORT = 2'd1,
    VERDICT_LCS_BAD   = 2'd2,
    VERDICT_DCS_BAD   = 2'd3
  } verdict_t;

  localparam int unsigned OUT_DATA_W = 32;

endpackage

// ===== design/nfc_response_frame_checker.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Width  tdata / tuser contents (lowest bit first)
// in_      in   8 / 1  tdata: rx_byte[7:0]; tuser: func (0 byte, 1 end of window)
// out_     out  32     tdata: verdict[1:0], frame_length[7:0], status_byte[7:0],
//                      bytes_received[8:0], zero pad
//
// One beat per cycle on the input unless it stalls; a byte beat leaves the input
// register the cycle after it lands and updates the window state there.
// An end-of-window beat moves into the result register once that has room
// and clears the window state in the same edge.
// The result register decouples the sides: input stalls only when an end
// beat sits in the input register and the previous result is still held.
// Reset (rst_n low, synchronous) empties both registers and clears the window.

`include "nfc_response_frame_checker_defines.svh"

module nfc_response_frame_checker
  import nfcrfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // rx_byte[7:0]
  input  logic                  in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // verdict, frame_length, status_byte,
                                            // bytes_received, pad
);

  // Input register
  logic       s_valid_r, s_valid_nxt;
  logic       s_func_r;
  logic [7:0] s_byte_r;

  // Window state
  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [7:0]         lcs_r, lcs_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [7:0]         dcs_r, dcs_nxt;
  logic [7:0]         status_r, status_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  verdict_t           verdict_r, verdict_nxt;
  logic [7:0]         flen_r;
  logic [7:0]         fstat_r;
  logic [COUNT_W-1:0] fcount_r;

  logic               s_adv;
  logic               s_byte_fire;
  logic               s_end_fire;
  logic               in_fire;
  logic [COUNT_W-1:0] data_end;

  // An end beat needs room in the result register; a byte beat never waits
  assign s_adv       = s_valid_r & ((s_func_r == FUNC_BYTE) | ~out_valid_r | out_tready);
  assign s_byte_fire = s_adv & (s_func_r == FUNC_BYTE);
  assign s_end_fire  = s_adv & (s_func_r == FUNC_END);
  assign in_tready   = ~s_valid_r | s_adv;
  assign in_fire     = in_tvalid & in_tready;

  // DCS sits right after the LEN data bytes
  assign data_end = POS_DATA + {{(COUNT_W-8){1'b0}}, len_r};

  always_comb begin
    s_valid_nxt    = in_fire | (s_valid_r & ~s_adv);

    byte_count_nxt = byte_count_r;
    len_nxt        = len_r;
    lcs_nxt        = lcs_r;
    sum_nxt        = sum_r;
    dcs_nxt        = dcs_r;
    status_nxt     = status_r;

    if (s_byte_fire && byte_count_r != COUNT_MAX) begin
      if (byte_count_r == POS_LEN) begin
        len_nxt = s_byte_r;
      end
      if (byte_count_r == POS_LCS) begin
        lcs_nxt = s_byte_r;
      end
      if (byte_count_r == POS_STATUS) begin
        status_nxt = s_byte_r;
      end
      if (byte_count_r >= POS_DATA && byte_count_r < data_end) begin
        sum_nxt = sum_r + s_byte_r;
      end
      if (byte_count_r == data_end) begin
        dcs_nxt = s_byte_r;
      end
      byte_count_nxt = byte_count_r + 1'b1;
    end else if (s_end_fire) begin
      byte_count_nxt = '0;
      len_nxt        = '0;
      lcs_nxt        = '0;
      sum_nxt        = '0;
      dcs_nxt        = '0;
      status_nxt     = '0;
    end

    // Checks in priority order: length, LCS, DCS
    if (byte_count_r < MIN_COUNT) begin
      verdict_nxt = VERDICT_TOO_SHORT;
    end else if (8'(8'd0 - len_r) != lcs_r) begin
      verdict_nxt = VERDICT_LCS_BAD;
    end else if (8'(8'd0 - sum_r) != dcs_r) begin
      verdict_nxt = VERDICT_DCS_BAD;
    end else begin
      verdict_nxt = VERDICT_OK;
    end

    out_valid_nxt = s_end_fire | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      byte_count_r <= '0;
      len_r        <= '0;
      lcs_r        <= '0;
      sum_r        <= '0;
      dcs_r        <= '0;
      status_r     <= '0;
    end else begin
      s_valid_r    <= s_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      byte_count_r <= byte_count_nxt;
      len_r        <= len_nxt;
      lcs_r        <= lcs_nxt;
      sum_r        <= sum_nxt;
      dcs_r        <= dcs_nxt;
      status_r     <= status_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_func_r <= in_tuser;
      s_byte_r <= in_tdata;
    end
    if (s_end_fire) begin
      verdict_r <= verdict_nxt;
      flen_r    <= len_r;
      fstat_r   <= status_r;
      fcount_r  <= byte_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - COUNT_W - 18){1'b0}},
                       fcount_r, fstat_r, flen_r, verdict_r};

  // ---- assertions ----
  `NFCRFC_ASSERT_NXT(a_clear_after_end, clk, rst_n, s_end_fire,
                     byte_count_r == '0 && sum_r == '0 && len_r == '0)
  `NFCRFC_ASSERT_NXT(a_count_step, clk, rst_n,
                     s_byte_fire && byte_count_r != COUNT_MAX,
                     byte_count_r == $past(byte_count_r) + 1'b1)
  `NFCRFC_ASSERT_IMP(a_short_verdict, clk, rst_n, out_valid_r && fcount_r < MIN_COUNT,
                     verdict_r == VERDICT_TOO_SHORT)
  `NFCRFC_ASSERT_NXT(a_end_held, clk, rst_n, s_valid_r && !s_adv,
                     s_valid_r && s_func_r == FUNC_END)

endmodule
